// ===== hdl/assert_macros.svh =====
// assertion macros shared by the sine/cosine pipeline
// define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// clocked property, switched off while reset is active
`define SCP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked property, checked during reset as well
`define SCP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SCP_ASSERT(lbl, clk, rst_n, prop, msg)
`define SCP_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== hdl/scp_pkg.sv =====
// ----------------------------------------------------------------------------
// scp_pkg
// Types, fixed-point constants and helpers of the sine/cosine pipeline.
// ----------------------------------------------------------------------------
package scp_pkg;

	// port field widths
	localparam int ANGLE_W = 32;
	localparam int VALUE_W = 16;

	// internal signed Q4.28 format
	localparam int QF     = 28;
	localparam int QW     = 32;
	localparam int PW     = 2 * QW;

	localparam logic signed [QW-1:0] Q_ONE  = QW'(64'sd1 <<< QF);
	localparam logic signed [PW-1:0] Q_HALF = PW'(64'sd1 <<< (QF - 1));

	// 1/pi as unsigned Q0.32, below 2^31
	localparam logic [30:0] INV_PI_Q32 = 31'd1367130551;

	// range reduction offsets, 1.0 for sine and 1.5 for cosine, modulo 2
	localparam logic [QF:0] OFS_SIN = (QF + 1)'(1) << QF;
	localparam logic [QF:0] OFS_COS = (QF + 1)'(3) << (QF - 1);

	// selector codes
	localparam logic ACT_SIN = 1'b0;
	localparam logic ACT_COS = 1'b1;

	// add terms of the multiply stages: Horner chain, then two tail products
	localparam int HORNER_N = 7;
	localparam logic signed [QW-1:0] HORNER_C [0:HORNER_N-1] = '{
		32'sd103599,
		-32'sd1841518,
		32'sd20182927,
		-32'sd140669883,
		32'sd543882302,
		-32'sd843314854,
		32'sd0
	};

	// reduced value and its square travelling beside the products
	typedef struct packed {
		logic signed [QW-1:0] x;
		logic signed [QW-1:0] x2;
	} scp_side_t;

	// full product back to Q.28, rounded half up
	function automatic logic signed [QW-1:0] q_round(input logic signed [PW-1:0] p);
		logic signed [PW-1:0] s;
		s = p + Q_HALF;
		return s[QF+QW-1:QF];
	endfunction

endpackage

// ===== hdl/scp_if.sv =====
// ----------------------------------------------------------------------------
// scp_arg_if / scp_res_if
// Valid/ready channels carrying angle beats in and result beats out.
// ----------------------------------------------------------------------------
interface scp_arg_if;
	logic                               valid;
	logic                               ready;
	logic                               action;
	logic signed [scp_pkg::ANGLE_W-1:0] angle;

	modport source (output valid, action, angle, input ready);
	modport sink (input valid, action, angle, output ready);
endinterface

interface scp_res_if;
	logic                               valid;
	logic                               ready;
	logic signed [scp_pkg::VALUE_W-1:0] value;

	modport source (output valid, value, input ready);
	modport sink (input valid, value, output ready);
endinterface

// ===== hdl/sine_cosine_polynomial.sv =====
// throughput: one beat per cycle while the output is not stalled;
// stages 1 to 9 each hold one multiplier
// a stalled output backs up through the stage chain; bubbles are squeezed out
// reset clears the stage valid bits only; no clearing pass, no stored state
// ----------------------------------------------------------------------------
// sine_cosine_polynomial
// Fixed-point sine/cosine by range reduction and an odd polynomial in Q4.28,
// result in signed Q1.15 with saturation.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sine_cosine_polynomial #(
	parameter int ANGLE_FRAC_BITS = 16,
	parameter int OUT_FRAC_BITS   = 15
) (
	input  logic          clk,
	input  logic          arst_n,
	scp_arg_if.sink       arg,
	scp_res_if.source     res
);
	import scp_pkg::*;

	localparam logic signed [PW-1:0] LIM_HI = (64'sd1 <<< OUT_FRAC_BITS) - 64'sd1;
	localparam logic signed [PW-1:0] LIM_LO = -(64'sd1 <<< OUT_FRAC_BITS);

	logic                 red_v;
	logic                 red_rdy;
	logic signed [QW-1:0] red_x;
	logic signed [PW-1:0] red_x2p;
	logic signed [QW-1:0] x2_d;

	logic                 v   [0:HORNER_N];
	logic                 rdy [0:HORNER_N];
	logic signed [PW-1:0] p   [0:HORNER_N];
	scp_side_t            side[0:HORNER_N];

	logic signed [QW-1:0] r_d;
	logic signed [PW-1:0] rw_d;
	logic signed [PW-1:0] conv_d;
	logic signed [PW-1:0] sat_d;
	logic                 vld_s10;
	logic [VALUE_W-1:0]   val_s10;

	// stages 1 and 2: scaling, reduction, square
	scp_reduce #(
		.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
	) u_reduce (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (arg.valid),
		.ready_in  (arg.ready),
		.action    (arg.action),
		.angle     (arg.angle),
		.valid_out (red_v),
		.ready_out (red_rdy),
		.x         (red_x),
		.x2p       (red_x2p)
	);

	// square rounded to Q.28 feeds the first multiply stage
	assign x2_d       = q_round(red_x2p);
	assign v[0]       = red_v;
	assign red_rdy    = rdy[0];
	assign p[0]       = '0;
	assign side[0].x  = red_x;
	assign side[0].x2 = x2_d;

	// stages 3 to 9: Horner chain in x^2, then times (x^2-1), then times x
	for (genvar i = 0; i < HORNER_N; i++) begin : g_mac
		logic signed [QW-1:0] opnd;

		if (i < HORNER_N - 2) begin : g_horner
			assign opnd = side[i].x2;
		end else if (i == HORNER_N - 2) begin : g_span
			assign opnd = side[i].x2 - Q_ONE;
		end else begin : g_odd
			assign opnd = side[i].x;
		end

		scp_mac_stage #(
			.COEF (HORNER_C[i])
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.valid_in  (v[i]),
			.ready_in  (rdy[i]),
			.p_in      (p[i]),
			.opnd      (opnd),
			.side_in   (side[i]),
			.valid_out (v[i+1]),
			.ready_out (rdy[i+1]),
			.p_out     (p[i+1]),
			.side_out  (side[i+1])
		);
	end

	// stage 10: round, move to the output format, saturate
	assign r_d  = q_round(p[HORNER_N]);
	assign rw_d = PW'(r_d);

	if (OUT_FRAC_BITS < QF) begin : g_shr
		localparam int SH = QF - OUT_FRAC_BITS;
		assign conv_d = (rw_d + (64'sd1 <<< (SH - 1))) >>> SH;
	end else begin : g_shl
		localparam int SH = OUT_FRAC_BITS - QF;
		assign conv_d = rw_d <<< SH;
	end

	always_comb begin
		sat_d = conv_d;
		if (conv_d > LIM_HI) begin
			sat_d = LIM_HI;
		end
		if (conv_d < LIM_LO) begin
			sat_d = LIM_LO;
		end
	end

	assign rdy[HORNER_N] = !vld_s10 || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s10 <= 1'b0;
		end else if (rdy[HORNER_N]) begin
			vld_s10 <= v[HORNER_N];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[HORNER_N] && v[HORNER_N]) begin
			val_s10 <= sat_d[VALUE_W-1:0];
		end
	end

	assign res.valid = vld_s10;
	assign res.value = val_s10;

	`SCP_ASSERT(a_sq_range, clk, arst_n, red_v |-> (x2_d >= 0) && (x2_d <= Q_ONE), "rounded square outside [0,1]")
	`SCP_ASSERT(a_out_take, clk, arst_n, (v[HORNER_N] && rdy[HORNER_N]) |=> vld_s10, "final beat dropped")
	`SCP_ASSERT_ALWAYS(a_back, clk, (vld_s10 && !res.ready) |-> !rdy[HORNER_N], "stalled output takes a beat")

endmodule

// ===== hdl/scp_reduce.sv =====
// ----------------------------------------------------------------------------
// scp_reduce
// Two stages: angle times 1/pi, then floored modulo 2 into [-1,1) and x*x.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scp_reduce #(
	parameter int ANGLE_FRAC_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               valid_in,
	output logic                               ready_in,
	input  logic                               action,
	input  logic signed [scp_pkg::ANGLE_W-1:0] angle,
	output logic                               valid_out,
	input  logic                               ready_out,
	output logic signed [scp_pkg::QW-1:0]      x,
	output logic signed [scp_pkg::PW-1:0]      x2p
);
	import scp_pkg::*;

	// low bit of the Q.28 window inside the scaled product
	localparam int LO = ANGLE_FRAC_BITS + 32 - QF;

	logic                   v_s1;
	logic                   act_s1;
	logic signed [PW-1:0]   prod_s1;
	logic                   v_s2;
	logic signed [QW-1:0]   x_s2;
	logic signed [PW-1:0]   x2p_s2;
	logic                   rdy_s1;
	logic                   rdy_s2;
	logic signed [PW-1:0]   prod_d;
	logic [QF:0]            t_d;
	logic [QF:0]            x29_d;
	logic signed [QW-1:0]   x_d;

	// stall chain: a stage moves when it is empty or its successor takes
	assign rdy_s2   = !v_s2 || ready_out;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign ready_in = rdy_s1;

	// stage 1: scale by 1/pi
	assign prod_d = $signed(angle) * $signed({1'b0, INV_PI_Q32});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && valid_in) begin
			prod_s1 <= prod_d;
			act_s1  <= action;
		end
	end

	// stage 2: add offset, keep 29 bits, recentre, then square
	always_comb begin
		t_d   = prod_s1[LO+QF:LO] + ((act_s1 == ACT_COS) ? OFS_COS : OFS_SIN);
		x29_d = {~t_d[QF], t_d[QF-1:0]};
		x_d   = {{(QW-QF-1){x29_d[QF]}}, x29_d};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			x_s2   <= x_d;
			x2p_s2 <= x_d * x_d;
		end
	end

	assign valid_out = v_s2;
	assign x         = x_s2;
	assign x2p       = x2p_s2;

	`SCP_ASSERT(a_x_range, clk, arst_n, v_s2 |-> (x_s2 >= -Q_ONE) && (x_s2 < Q_ONE), "reduced value outside [-1,1)")
	`SCP_ASSERT(a_sq_sign, clk, arst_n, v_s2 |-> !x2p_s2[PW-1], "square came out negative")
	`SCP_ASSERT(a_take_in, clk, arst_n, (valid_in && rdy_s1) |=> v_s1, "accepted beat lost at stage 1")

endmodule

// ===== hdl/scp_mac_stage.sv =====
// ----------------------------------------------------------------------------
// scp_mac_stage
// One pipeline stage: round the incoming product to Q.28, add a constant and
// multiply by an operand; the side data travels along.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scp_mac_stage #(
	parameter logic signed [31:0] COEF = 32'sd0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          valid_in,
	output logic                          ready_in,
	input  logic signed [scp_pkg::PW-1:0] p_in,
	input  logic signed [scp_pkg::QW-1:0] opnd,
	input  scp_pkg::scp_side_t            side_in,
	output logic                          valid_out,
	input  logic                          ready_out,
	output logic signed [scp_pkg::PW-1:0] p_out,
	output scp_pkg::scp_side_t            side_out
);
	import scp_pkg::*;

	logic                 v_q;
	logic signed [PW-1:0] p_q;
	scp_side_t            side_q;
	logic signed [QW-1:0] h_d;
	logic                 adv;

	assign adv      = !v_q || ready_out;
	assign ready_in = adv;

	// round, add the stage constant
	assign h_d = q_round(p_in) + COEF;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (adv) begin
			v_q <= valid_in;
		end
	end

	// product register
	always_ff @(posedge clk) begin
		if (adv && valid_in) begin
			p_q    <= h_d * opnd;
			side_q <= side_in;
		end
	end

	assign valid_out = v_q;
	assign p_out     = p_q;
	assign side_out  = side_q;

	`SCP_ASSERT(a_take, clk, arst_n, (valid_in && adv) |=> v_q, "accepted beat dropped")
	`SCP_ASSERT(a_hold, clk, arst_n, (v_q && !ready_out) |=> v_q && $stable(p_q) && $stable(side_q), "stalled stage changed")
	`SCP_ASSERT(a_back, clk, arst_n, (v_q && !ready_out) |-> !ready_in, "full stalled stage takes a beat")

endmodule

// ===== bench/sine_cosine_polynomial_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sine_cosine_polynomial_tb
// Drives angle beats through the sine/cosine pipeline and checks every result
// beat against a fixed-point predictor, under several sender and receiver
// idling patterns and one long receiver hold-off.
// ----------------------------------------------------------------------------
module sine_cosine_polynomial_tb;
	import scp_pkg::*;

	localparam int ANGLE_FRAC   = 16;
	localparam int OUT_FRAC     = 15;
	localparam int PIPE_LATENCY = 10;
	localparam int HOLD_CYCLES  = 250;
	localparam int TIMEOUT_NS   = 4_000_000;

	// predictor constants, Q.28 apart from RECIP_PI in Q0.32 and the mask
	localparam int     FRAC_Q    = 28;
	localparam longint RECIP_PI  = 64'sd1367130551;
	localparam longint Q28_ONE   = 64'sd1 <<< FRAC_Q;
	localparam longint Q28_HALF  = 64'sd1 <<< (FRAC_Q - 1);
	localparam longint OFFSET_SIN = 64'sd1 <<< FRAC_Q;
	localparam longint OFFSET_COS = 64'sd3 <<< (FRAC_Q - 1);
	localparam longint MOD2_MASK = (64'sd1 <<< (FRAC_Q + 1)) - 64'sd1;
	localparam longint COEF_0    = 64'sd103599;
	localparam longint COEF_1    = 64'sd1841518;
	localparam longint COEF_2    = 64'sd20182927;
	localparam longint COEF_3    = 64'sd140669883;
	localparam longint COEF_4    = 64'sd543882302;
	localparam longint COEF_5    = 64'sd843314854;

	typedef struct {
		logic                       action;
		logic signed [ANGLE_W-1:0] angle;
	} angle_beat_t;

	typedef struct {
		logic                       action;
		logic signed [ANGLE_W-1:0] angle;
		logic signed [VALUE_W-1:0] value;
	} sincos_result_t;

	logic clk;
	logic arst_n = 1'b0;

	angle_beat_t    angle_beats[$];
	sincos_result_t expected_results[$];
	sincos_result_t oldest_result;

	int   mismatches     = 0;
	int   send_idle_pct  = 0;
	int   recv_stall_pct = 0;
	logic arg_fired      = 1'b0;
	logic hold_request   = 1'b0;
	logic hold_ready     = 1'b0;

	scp_arg_if arg_ch ();
	scp_res_if res_ch ();

	sine_cosine_polynomial #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC),
		.OUT_FRAC_BITS  (OUT_FRAC)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.arg   (arg_ch),
		.res   (res_ch)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// product of two q.28 values, rounded half up
	function automatic longint mul_q28(input longint a, input longint b);
		return (a * b + Q28_HALF) >>> FRAC_Q;
	endfunction

	// expected sine or cosine of one angle beat, q1.15 saturated
	function automatic logic signed [VALUE_W-1:0] sincos_q15(input logic act,
			input logic signed [ANGLE_W-1:0] ang);
		longint          scaled;
		longint unsigned turns;
		longint          x, x2, horner, r, lim;
		scaled = longint'(ang) * RECIP_PI;
		turns  = longint'(scaled) >> (ANGLE_FRAC + 32 - FRAC_Q);
		turns  = turns + ((act == ACT_COS) ? OFFSET_COS : OFFSET_SIN);
		x      = longint'(turns & MOD2_MASK) - Q28_ONE;
		x2     = mul_q28(x, x);
		horner = COEF_0;
		horner = mul_q28(horner, x2) - COEF_1;
		horner = mul_q28(horner, x2) + COEF_2;
		horner = mul_q28(horner, x2) - COEF_3;
		horner = mul_q28(horner, x2) + COEF_4;
		horner = mul_q28(horner, x2) - COEF_5;
		r = mul_q28(x - Q28_ONE, x + Q28_ONE);
		r = mul_q28(r, horner);
		r = mul_q28(r, x);
		// down to the output format, half up, then clamp
		r   = (r + (64'sd1 <<< (FRAC_Q - OUT_FRAC - 1))) >>> (FRAC_Q - OUT_FRAC);
		lim = 64'sd1 <<< OUT_FRAC;
		if (r > lim - 1) begin
			r = lim - 1;
		end
		if (r < -lim) begin
			r = -lim;
		end
		return r[VALUE_W-1:0];
	endfunction

	task automatic report_mismatch(input string what);
		$display("%0t ns  mismatch: %s", $time, what);
		mismatches++;
	endtask

	// angle beat driver, fed from the pending queue
	always @(negedge clk) begin
		if (!arst_n) begin
			arg_ch.valid  <= 1'b0;
			arg_ch.action <= ACT_SIN;
			arg_ch.angle  <= '0;
		end else if (!arg_ch.valid || arg_fired) begin
			if (angle_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				arg_ch.valid  <= 1'b1;
				arg_ch.action <= angle_beats[0].action;
				arg_ch.angle  <= angle_beats[0].angle;
				void'(angle_beats.pop_front());
			end else begin
				// idle: payload is noise
				arg_ch.valid  <= 1'b0;
				arg_ch.action <= 1'($urandom);
				arg_ch.angle  <= $urandom;
			end
		end
	end

	// result ready, random stalls plus the long hold-off
	always @(negedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= !hold_ready && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// long receiver hold-off so the pipeline fills and backs up
	initial begin
		wait (hold_request);
		@(negedge clk);
		hold_ready <= 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		hold_ready <= 1'b0;
	end

	// monitor: check result beats, then predict accepted angle beats
	always @(posedge clk) begin
		if (!arst_n) begin
			arg_fired <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("result beat %0d with no angle beat waiting",
						res_ch.value));
				end else begin
					oldest_result = expected_results.pop_front();
					if (res_ch.value !== oldest_result.value) begin
						report_mismatch($sformatf("action %0d angle %0d: value %0d, expected %0d",
							oldest_result.action, oldest_result.angle, res_ch.value,
							oldest_result.value));
					end
				end
			end
			if (arg_ch.valid && arg_ch.ready) begin
				expected_results.push_back('{arg_ch.action, arg_ch.angle,
					sincos_q15(arg_ch.action, arg_ch.angle)});
			end
			arg_fired <= arg_ch.valid && arg_ch.ready;
		end
	end

	// one idling pattern: random angles, then wait for every result
	task automatic run_phase(input int send_pct, input int recv_pct, input int count);
		angle_beat_t beat;
		int          quarter;
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		repeat (count) begin
			beat.action = 1'($urandom);
			case ($urandom_range(2))
				0: begin
					beat.angle = $urandom;
				end
				1: begin
					// within about sixteen radians either side
					beat.angle = $urandom_range(2097152);
					beat.angle = beat.angle - 32'sd1048576;
				end
				default: begin
					// close to a multiple of a quarter turn, where clamping bites
					quarter    = int'($urandom_range(40)) - 20;
					beat.angle = quarter * 102944 + int'($urandom_range(8)) - 4;
				end
			endcase
			angle_beats.push_back(beat);
		end
		while (angle_beats.size() != 0 || arg_ch.valid || expected_results.size() != 0)
			@(posedge clk);
	endtask

	// timeout
	initial begin
		#(TIMEOUT_NS);
		$display("sine_cosine_polynomial_tb: FAIL");
		$finish;
	end

	// stimulus and verdict
	initial begin
		logic signed [ANGLE_W-1:0] edge_angles[12];
		arg_ch.valid  = 1'b0;
		arg_ch.action = ACT_SIN;
		arg_ch.angle  = '0;
		res_ch.ready  = 1'b0;
		// zero, one lsb, range ends, quarter, half and full turns, one radian
		edge_angles = '{32'sd0, 32'sd1, -32'sd1, 32'sh7FFFFFFF, 32'sh80000000,
			32'sd102944, -32'sd102944, 32'sd102943, 32'sd205887, -32'sd205887,
			32'sd411775, 32'sd65536};
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed beats, both selectors on every angle
		foreach (edge_angles[i]) begin
			angle_beats.push_back('{ACT_SIN, edge_angles[i]});
			angle_beats.push_back('{ACT_COS, edge_angles[i]});
		end

		run_phase(0, 0, 150);
		run_phase(62, 0, 130);
		run_phase(0, 62, 130);
		run_phase(6, 6, 120);
		hold_request = 1'b1;
		run_phase(0, 0, 120);

		repeat (3 * PIPE_LATENCY) @(posedge clk);
		foreach (expected_results[i]) begin
			report_mismatch($sformatf("no result for action %0d angle %0d",
				expected_results[i].action, expected_results[i].angle));
		end
		if (mismatches == 0) begin
			$display("sine_cosine_polynomial_tb: PASS");
		end else begin
			$display("sine_cosine_polynomial_tb: FAIL");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/scp_pkg.sv
hdl/scp_if.sv
hdl/scp_reduce.sv
hdl/scp_mac_stage.sv
hdl/sine_cosine_polynomial.sv
bench/sine_cosine_polynomial_tb.sv
